// File: rtl/core/msc_pkg.sv
// Shared constants and types for the min-sum check node.
// No dependencies; every other file in rtl/core imports this package.
package msc_pkg;

    localparam int MSC_MAX_DEGREE     = 32;
    localparam int MSC_LLR_WIDTH      = 16;
    // Rows that may sit between front and back; the message RAM has one bank per row.
    localparam int MSC_ROWS_IN_FLIGHT = 2;

    typedef enum logic {
        BK_FETCH,
        BK_EMIT
    } t_back_state;

endpackage

// File: rtl/core/msc_front.sv
// Front end: accepts message beats, writes them to the message RAM and keeps
// running row statistics (sign product, two smallest magnitudes). Uses msc_pkg.
module msc_front import msc_pkg::*; #(
    parameter int MAX_DEGREE = MSC_MAX_DEGREE,
    parameter int LLR_WIDTH  = MSC_LLR_WIDTH,
    localparam int CNT_W  = $clog2(MAX_DEGREE + 1),
    localparam int IDX_W  = $clog2(MAX_DEGREE),
    localparam int MAG_W  = LLR_WIDTH - 1,
    localparam int DESC_W = CNT_W + 3 + IDX_W + 2 * MAG_W + 2 * LLR_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [LLR_WIDTH-1:0] i_edge_message,
    input  logic signed [LLR_WIDTH-1:0] i_partner_value,
    input  logic                        i_last_edge,
    input  logic                        i_full,
    output logic                        o_wr_en,
    output logic [IDX_W:0]              o_wr_addr,
    output logic [LLR_WIDTH-1:0]        o_wr_data,
    output logic                        o_push,
    output logic [DESC_W-1:0]           o_desc
);

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_ovf, n_ovf;
    logic                 r_bank;
    logic                 r_neg, n_neg;
    logic [MAG_W-1:0]     r_min1, n_min1;
    logic [MAG_W-1:0]     r_min2, n_min2;
    logic [IDX_W-1:0]     r_min_idx, n_min_idx;
    logic [LLR_WIDTH-1:0] r_first, n_first;

    logic                 accept;
    logic                 room;
    logic                 msg_neg;
    logic [LLR_WIDTH-1:0] msg_abs;
    logic [MAG_W-1:0]     msg_mag;
    logic [LLR_WIDTH-1:0] row_value;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        msg_neg   = i_edge_message[LLR_WIDTH-1];
        msg_abs   = msg_neg ? (~i_edge_message + LLR_WIDTH'(1)) : i_edge_message;
        // only the most negative code sets the top bit of the absolute value
        msg_mag   = msg_abs[LLR_WIDTH-1] ? MAG_MAX : msg_abs[MAG_W-1:0];
        room      = r_count < CNT_W'(MAX_DEGREE);
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_neg     = r_neg;
        n_min1    = r_min1;
        n_min2    = r_min2;
        n_min_idx = r_min_idx;
        n_first   = r_first;
        if (room) begin
            n_count = r_count + CNT_W'(1);
            if (r_count == '0) begin
                n_neg     = msg_neg;
                n_min1    = msg_mag;
                n_min2    = MAG_MAX;
                n_min_idx = '0;
                n_first   = i_edge_message;
            end else begin
                n_neg = r_neg ^ msg_neg;
                if (msg_mag < r_min1) begin
                    n_min2    = r_min1;
                    n_min1    = msg_mag;
                    n_min_idx = r_count[IDX_W-1:0];
                end else if (msg_mag < r_min2) begin
                    n_min2 = msg_mag;
                end
            end
        end else begin
            n_ovf = 1'b1;
        end
        if (n_count == CNT_W'(1)) begin
            row_value = n_first;
        end else if (n_neg) begin
            row_value = LLR_WIDTH'(0) - {1'b0, n_min1};
        end else begin
            row_value = {1'b0, n_min1};
        end
    end

    assign o_wr_en   = accept && room;
    assign o_wr_addr = {r_bank, r_count[IDX_W-1:0]};
    assign o_wr_data = i_edge_message;
    assign o_push    = accept && i_last_edge;
    assign o_desc    = {n_count, n_ovf, r_bank, n_neg, n_min_idx, n_min1, n_min2,
                        row_value, i_partner_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_bank  <= 1'b0;
        end else if (accept) begin
            if (i_last_edge) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_bank  <= ~r_bank;
            end else begin
                r_count <= n_count;
                r_ovf   <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg     <= n_neg;
            r_min1    <= n_min1;
            r_min2    <= n_min2;
            r_min_idx <= n_min_idx;
            r_first   <= n_first;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_DEGREE))
        else $error("edge count above maximum degree");

    a_ovf_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_count == CNT_W'(MAX_DEGREE))
        else $error("overflow set on a row that is not full");

endmodule

// File: rtl/core/msc_row_fifo.sv
// Two-entry queue of closed-row descriptors between front and back.
// Entries stay until the back has emitted the whole row. Uses msc_pkg.
module msc_row_fifo import msc_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_slot [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_data  = r_slot[r_rd_ptr];
    assign o_full  = r_count == 2'(MSC_ROWS_IN_FLIGHT);
    assign o_empty = r_count == 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("row queue push while full");

endmodule

// File: rtl/core/msc_back.sv
// Back end: holds the double-banked message RAM, reads one stored message per
// result, forms the corrected extrinsic value and drives the output register.
// Uses msc_pkg.
module msc_back import msc_pkg::*; #(
    parameter int MAX_DEGREE = MSC_MAX_DEGREE,
    parameter int LLR_WIDTH  = MSC_LLR_WIDTH,
    localparam int CNT_W  = $clog2(MAX_DEGREE + 1),
    localparam int IDX_W  = $clog2(MAX_DEGREE),
    localparam int MAG_W  = LLR_WIDTH - 1,
    localparam int DESC_W = CNT_W + 3 + IDX_W + 2 * MAG_W + 2 * LLR_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [IDX_W:0]              i_wr_addr,
    input  logic [LLR_WIDTH-1:0]        i_wr_data,
    input  logic [DESC_W-1:0]           i_desc,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [LLR_WIDTH-1:0] o_extrinsic,
    output logic signed [LLR_WIDTH-1:0] o_row_value,
    output logic                        o_overflow,
    output logic                        o_last_result
);

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    logic [LLR_WIDTH-1:0] r_mem [2 ** (IDX_W + 1)];
    logic [LLR_WIDTH-1:0] r_rd_data;

    t_back_state          r_state, n_state;
    logic [IDX_W-1:0]     r_idx;
    logic                 rd_en;
    logic                 load;

    logic [CNT_W-1:0]     d_count;
    logic                 d_ovf;
    logic                 d_bank;
    logic                 d_neg;
    logic [IDX_W-1:0]     d_min_idx;
    logic [MAG_W-1:0]     d_min1;
    logic [MAG_W-1:0]     d_min2;
    logic [LLR_WIDTH-1:0] d_row_value;
    logic [LLR_WIDTH-1:0] d_partner;

    logic                 is_last;
    logic                 edge_neg;
    logic [MAG_W-1:0]     edge_mag;
    logic                 p_neg;
    logic [LLR_WIDTH-1:0] p_abs;
    logic [MAG_W-1:0]     p_mag;
    logic                 out_neg;
    logic [MAG_W-1:0]     out_mag;
    logic [LLR_WIDTH-1:0] ext;

    logic                 r_out_valid;
    logic [LLR_WIDTH-1:0] r_ext;
    logic [LLR_WIDTH-1:0] r_row_value;
    logic                 r_ovf;
    logic                 r_last;

    assign {d_count, d_ovf, d_bank, d_neg, d_min_idx, d_min1, d_min2,
            d_row_value, d_partner} = i_desc;

    assign is_last = (CNT_W'(r_idx) + CNT_W'(1)) == d_count;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[{d_bank, r_idx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_FETCH;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        load    = 1'b0;
        o_pop   = 1'b0;
        unique case (r_state)
            BK_FETCH: begin
                if (!i_empty) begin
                    rd_en   = 1'b1;
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (!r_out_valid || !i_stall) begin
                    load    = 1'b1;
                    o_pop   = is_last;
                    n_state = BK_FETCH;
                end
            end
            default: n_state = BK_FETCH;
        endcase
    end

    always_comb begin
        edge_neg = d_neg ^ r_rd_data[LLR_WIDTH-1];
        edge_mag = (r_idx == d_min_idx) ? d_min2 : d_min1;
        p_neg    = d_partner[LLR_WIDTH-1];
        p_abs    = p_neg ? (~d_partner + LLR_WIDTH'(1)) : d_partner;
        p_mag    = p_abs[LLR_WIDTH-1] ? MAG_MAX : p_abs[MAG_W-1:0];
        if (d_partner == '0) begin
            out_neg = edge_neg;
            out_mag = edge_mag;
        end else begin
            // a zero magnitude carries no sign into the correction
            out_neg = (edge_neg && (edge_mag != '0)) ^ p_neg;
            out_mag = (p_mag < edge_mag) ? p_mag : edge_mag;
        end
        if (d_count == CNT_W'(1)) begin
            ext = d_partner;
        end else if (out_neg) begin
            ext = LLR_WIDTH'(0) - {1'b0, out_mag};
        end else begin
            ext = {1'b0, out_mag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx       <= is_last ? '0 : r_idx + IDX_W'(1);
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ext       <= ext;
            r_row_value <= d_row_value;
            r_ovf       <= d_ovf;
            r_last      <= is_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_extrinsic   = r_ext;
    assign o_row_value   = r_row_value;
    assign o_overflow    = r_ovf;
    assign o_last_result = r_last;

    a_emit_has_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_EMIT |-> !i_empty)
        else $error("emitting with no row descriptor queued");

    a_idx_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> CNT_W'(r_idx) < d_count)
        else $error("edge index past end of row");

    a_ovf_full_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && d_ovf) |-> d_count == CNT_W'(MAX_DEGREE))
        else $error("overflow row without maximum degree");

endmodule

// File: rtl/core/min_sum_check_node.sv
// Top level of the min-sum LDPC check node: front end, row queue and back end.
// Depends on msc_pkg, msc_front, msc_row_fifo and msc_back.
//
//  Channel   Direction  Handshake          Fields
//  input     in         i_valid / o_stall  i_edge_message, i_partner_value, i_last_edge
//  output    out        o_valid / i_stall  o_extrinsic, o_row_value, o_overflow,
//                                          o_last_result
//
// The front end takes one message beat per cycle while o_stall is low; a row closes on the beat with i_last_edge.
// Each result passes two back-end steps, a message RAM read (BK_FETCH) and then the output register (BK_EMIT).
// Two rows may be in flight (one RAM bank each); the input stalls while both are pending.
// Reset is synchronous on i_rst_n low and empties the row queue; the RAM needs no clearing.
// A stalled output holds its beat; the back end reads the next message and waits on it.
module min_sum_check_node import msc_pkg::*; #(
    parameter int MAX_DEGREE = MSC_MAX_DEGREE,
    parameter int LLR_WIDTH  = MSC_LLR_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [LLR_WIDTH-1:0] i_edge_message,
    input  logic signed [LLR_WIDTH-1:0] i_partner_value,
    input  logic                        i_last_edge,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [LLR_WIDTH-1:0] o_extrinsic,
    output logic signed [LLR_WIDTH-1:0] o_row_value,
    output logic                        o_overflow,
    output logic                        o_last_result
);

    localparam int CNT_W  = $clog2(MAX_DEGREE + 1);
    localparam int IDX_W  = $clog2(MAX_DEGREE);
    localparam int MAG_W  = LLR_WIDTH - 1;
    localparam int DESC_W = CNT_W + 3 + IDX_W + 2 * MAG_W + 2 * LLR_WIDTH;

    logic                 wr_en;
    logic [IDX_W:0]       wr_addr;
    logic [LLR_WIDTH-1:0] wr_data;
    logic                 push;
    logic                 pop;
    logic                 full;
    logic                 empty;
    logic [DESC_W-1:0]    desc_in;
    logic [DESC_W-1:0]    desc_out;

    msc_front #(
        .MAX_DEGREE (MAX_DEGREE),
        .LLR_WIDTH  (LLR_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_edge_message  (i_edge_message),
        .i_partner_value (i_partner_value),
        .i_last_edge     (i_last_edge),
        .i_full          (full),
        .o_wr_en         (wr_en),
        .o_wr_addr       (wr_addr),
        .o_wr_data       (wr_data),
        .o_push          (push),
        .o_desc          (desc_in)
    );

    msc_row_fifo #(
        .WIDTH (DESC_W)
    ) u_row_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (desc_in),
        .i_pop   (pop),
        .o_data  (desc_out),
        .o_full  (full),
        .o_empty (empty)
    );

    msc_back #(
        .MAX_DEGREE (MAX_DEGREE),
        .LLR_WIDTH  (LLR_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (wr_en),
        .i_wr_addr     (wr_addr),
        .i_wr_data     (wr_data),
        .i_desc        (desc_out),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_extrinsic   (o_extrinsic),
        .o_row_value   (o_row_value),
        .o_overflow    (o_overflow),
        .o_last_result (o_last_result)
    );

endmodule
